### hw/rtl/posl_pkg.sv
// ----------------------------------------------------------------------------
// posl_pkg
// shared types and constants for the positional array list
// ----------------------------------------------------------------------------
package posl_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int CMD_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 128;
  localparam int GROUP_MAX    = 32;   // most cells looked at per scan cycle

  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_MODIFY = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_MODIFY,
    WR_INSERT,
    WR_REMOVE
  } wr_op_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic   mark;     // capture hit flags into the scan registers
    logic   scan;     // move scan registers one group toward cell zero
    logic   by_pos;   // hit means "my index is the position" (else value match)
    wr_op_t op;       // store update applied this cycle
  } cell_ctrl_t;

endpackage

### hw/rtl/posl_cell.sv
// ----------------------------------------------------------------------------
// posl_cell
// one list entry with its shift links and scan register
// ----------------------------------------------------------------------------
module posl_cell #(
  parameter int CAPACITY = posl_pkg::DEF_CAPACITY,
  parameter int INDEX    = 0,
  parameter int IW       = 7,
  parameter int PW       = 8
) (
  input  logic                         clk,
  input  posl_pkg::cell_ctrl_t         ctrl,
  input  logic [IW-1:0]                pos_idx,
  input  logic [PW-1:0]                count,
  input  logic [posl_pkg::DATA_W-1:0]  value,
  input  logic [posl_pkg::DATA_W-1:0]  left_data,
  input  logic [posl_pkg::DATA_W-1:0]  right_data,
  output logic [posl_pkg::DATA_W-1:0]  data,
  input  logic                         scan_hit_in,
  input  logic [posl_pkg::DATA_W-1:0]  scan_dat_in,
  output logic                         scan_hit,
  output logic [posl_pkg::DATA_W-1:0]  scan_dat
);
  import posl_pkg::*;

  logic here;
  logic after;
  logic live;

  assign here  = (pos_idx == IW'(INDEX));
  assign after = (IW'(INDEX) > pos_idx);
  assign live  = (PW'(INDEX) < count) && (INDEX < CAPACITY);

  // entry word, undefined until written
  always_ff @(posedge clk) begin
    case (ctrl.op)
      WR_MODIFY: begin
        if (here) data <= value;
      end
      WR_INSERT: begin
        if (here) begin
          data <= value;
        end else if (after) begin
          data <= left_data;
        end
      end
      WR_REMOVE: begin
        if (here || after) data <= right_data;
      end
      default: begin
      end
    endcase
  end

  // scan register: hit flag plus word when addressed by position
  always_ff @(posedge clk) begin
    if (ctrl.mark) begin
      scan_hit <= ctrl.by_pos ? here : (live && (data == value));
      scan_dat <= (ctrl.by_pos && here) ? data : '0;
    end else if (ctrl.scan) begin
      scan_hit <= scan_hit_in;
      scan_dat <= scan_dat_in;
    end
  end

endmodule

### hw/rtl/posl_scan.sv
// ----------------------------------------------------------------------------
// posl_scan
// first-hit encoder and word merge over the lowest group of cells
// ----------------------------------------------------------------------------
module posl_scan #(
  parameter int GROUP = posl_pkg::GROUP_MAX,
  parameter int KW    = 5
) (
  input  logic [GROUP-1:0]                        hit,
  input  logic [GROUP-1:0][posl_pkg::DATA_W-1:0]  dat,
  output logic                                    any,
  output logic [KW-1:0]                           idx,
  output logic [posl_pkg::DATA_W-1:0]             merged
);
  import posl_pkg::*;

  always_comb begin
    any    = |hit;
    idx    = '0;
    merged = '0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (hit[i]) idx = KW'(i);
    end
    // only one cell carries a word, the rest are zero
    for (int i = 0; i < GROUP; i++) begin
      merged = merged | dat[i];
    end
  end

endmodule

### hw/rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// fixed-capacity ordered list of signed words held in a row of shifting cells
// ----------------------------------------------------------------------------
//
//  channel | dir | fields (tdata, lowest bit first)
//  --------+-----+---------------------------------------------------------
//  s_axis  | in  | command[2:0] position[10:3] value[42:11], zero to 48
//  m_axis  | out | status[1:0] data_out[33:2] found_position[41:34]
//          |     | count[49:42] is_empty[50] is_full[51], zero to 56
//
//  one beat in gives exactly one beat out; one request is worked at a time
//  modify, insert, bad positions and unused commands skip mark and scan
//  read and remove scan to the addressed cell, search to the first match or
//  the last group; the scan moves hit flags down one group (up to 32) at a time
//  rst clears the count and control only; entry words stay undefined
//  a result waiting on m_tready stalls only the final step, not acceptance
//
module positional_array_list #(
  parameter int CAPACITY = posl_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  // command, position, value
  input  logic [posl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // status, data_out, found_position, count, is_empty, is_full
  output logic [posl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready
);
  import posl_pkg::*;

  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW    = $clog2(CAPACITY + 1);
  localparam int GROUP = (CAPACITY < GROUP_MAX) ? CAPACITY : GROUP_MAX;
  localparam int NG    = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
  localparam int KW    = (GROUP > 1) ? $clog2(GROUP) : 1;
  // wide enough for position, count and count + 1
  localparam int CW    = ((PW > POS_W) ? PW : POS_W) + 1;
  localparam int PAD_W = OUT_TDATA_W - (STATUS_W + DATA_W + 2 * POS_W + 2);

  // input beat fields
  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;

  assign in_cmd = s_tdata[CMD_W-1:0];
  assign in_pos = s_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_val = s_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];

  // control state
  state_t      state, state_next;
  logic [PW-1:0] count, count_next;
  logic [GW-1:0] grp, grp_next;
  logic          out_valid;
  logic          load_out;

  // request being worked
  cmd_t          cmd_q;
  logic [IW-1:0] pos_idx, pos_idx_next;
  logic [DATA_W-1:0] val_q;
  status_t       status_q, status_next;
  logic [DATA_W-1:0] data_q, data_next;
  logic [PW-1:0] found_q, found_next;
  logic [OUT_TDATA_W-1:0] out_beat;

  cell_ctrl_t    ctrl;

  // cell row
  logic [DATA_W-1:0] cdata [CAPACITY];
  logic              chit  [CAPACITY];
  logic [DATA_W-1:0] cdat  [CAPACITY];

  logic [GROUP-1:0]              grp_hit;
  logic [GROUP-1:0][DATA_W-1:0]  grp_dat;
  logic                          sc_any;
  logic [KW-1:0]                 sc_idx;
  logic [DATA_W-1:0]             sc_word;

  // request decode
  logic [CW-1:0] pos_w;
  logic [CW-1:0] cnt_w;
  logic          pos_in_list;
  logic          pos_in_gap;
  logic          is_full_now;

  assign pos_w       = CW'(in_pos);
  assign cnt_w       = CW'(count);
  assign pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_in_gap  = (pos_w != '0) && (pos_w <= cnt_w + CW'(1));
  assign is_full_now = (count == PW'(CAPACITY));

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_beat;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      logic              sin_hit;
      logic [DATA_W-1:0] sin_dat;

      if (gi == 0) begin : g_first
        assign left_d = cdata[gi];
      end else begin : g_mid_l
        assign left_d = cdata[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cdata[gi];
      end else begin : g_mid_r
        assign right_d = cdata[gi+1];
      end

      // scan registers move down by one group per scan cycle
      if (gi + GROUP < CAPACITY) begin : g_feed
        assign sin_hit = chit[gi+GROUP];
        assign sin_dat = cdat[gi+GROUP];
      end else begin : g_tail
        assign sin_hit = 1'b0;
        assign sin_dat = '0;
      end

      posl_cell #(
        .CAPACITY (CAPACITY),
        .INDEX    (gi),
        .IW       (IW),
        .PW       (PW)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .pos_idx     (pos_idx),
        .count       (count),
        .value       (val_q),
        .left_data   (left_d),
        .right_data  (right_d),
        .data        (cdata[gi]),
        .scan_hit_in (sin_hit),
        .scan_dat_in (sin_dat),
        .scan_hit    (chit[gi]),
        .scan_dat    (cdat[gi])
      );
    end

    // the scanner always looks at the lowest group
    for (gi = 0; gi < GROUP; gi++) begin : g_grp
      assign grp_hit[gi] = chit[gi];
      assign grp_dat[gi] = cdat[gi];
    end
  endgenerate

  posl_scan #(
    .GROUP (GROUP),
    .KW    (KW)
  ) u_scan (
    .hit    (grp_hit),
    .dat    (grp_dat),
    .any    (sc_any),
    .idx    (sc_idx),
    .merged (sc_word)
  );

  // next state and cell control
  always_comb begin
    state_next   = state;
    count_next   = count;
    grp_next     = grp;
    pos_idx_next = pos_idx;
    status_next  = status_q;
    data_next    = data_q;
    found_next   = found_q;
    load_out     = 1'b0;
    ctrl         = '{mark: 1'b0, scan: 1'b0, by_pos: 1'b0, op: WR_NONE};

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          data_next    = '0;
          found_next   = '0;
          grp_next     = '0;
          pos_idx_next = IW'(pos_w - CW'(1));
          status_next  = ST_OK;
          state_next   = S_FINISH;
          case (cmd_t'(in_cmd))
            CMD_READ, CMD_REMOVE: begin
              if (!pos_in_list) begin
                status_next = ST_BADPOS;
              end else begin
                state_next = S_MARK;
              end
            end
            CMD_MODIFY: begin
              if (!pos_in_list) status_next = ST_BADPOS;
            end
            CMD_INSERT: begin
              if (is_full_now) begin
                status_next = ST_FULL;
              end else if (!pos_in_gap) begin
                status_next = ST_BADPOS;
              end
            end
            CMD_SEARCH: begin
              status_next = ST_NOTFOUND;
              state_next  = S_MARK;
            end
            default: begin
            end
          endcase
        end
      end

      S_MARK: begin
        ctrl.mark   = 1'b1;
        ctrl.by_pos = (cmd_q != CMD_SEARCH);
        state_next  = S_SCAN;
      end

      S_SCAN: begin
        if (sc_any) begin
          status_next = ST_OK;
          if (cmd_q == CMD_SEARCH) begin
            found_next = PW'(grp) * PW'(GROUP) + PW'(sc_idx) + PW'(1);
          end else begin
            data_next = sc_word;
          end
          state_next = S_FINISH;
        end else if (grp == GW'(NG - 1)) begin
          state_next = S_FINISH;
        end else begin
          ctrl.scan = 1'b1;
          grp_next  = grp + GW'(1);
        end
      end

      S_FINISH: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          if (status_q == ST_OK) begin
            case (cmd_q)
              CMD_MODIFY: begin
                ctrl.op = WR_MODIFY;
              end
              CMD_INSERT: begin
                ctrl.op    = WR_INSERT;
                count_next = count + PW'(1);
              end
              CMD_REMOVE: begin
                ctrl.op    = WR_REMOVE;
                count_next = count - PW'(1);
              end
              default: begin
              end
            endcase
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      grp       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      grp   <= grp_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      cmd_q <= cmd_t'(in_cmd);
      val_q <= in_val;
    end
    pos_idx  <= pos_idx_next;
    status_q <= status_next;
    data_q   <= data_next;
    found_q  <= found_next;
    if (load_out) begin
      out_beat <= {PAD_W'(0),
                   (count_next == PW'(CAPACITY)),
                   (count_next == '0),
                   POS_W'(count_next),
                   POS_W'(found_q),
                   data_q,
                   status_q};
    end
  end

endmodule
